// ----- src/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the scanline track edge and center tracker.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Line storage
  localparam int unsigned LINES  = 128;
  localparam int unsigned LINE_W = $clog2(LINES);

  localparam int unsigned POS_W   = 8;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned TIMER_W = 32;
  localparam int unsigned QUOT_W  = 29;

  // Divide by 13: q = (x * (2^32 + DIV13_MUL)) >> DIV13_SHIFT, exact for 32-bit x.
  localparam logic [29:0] DIV13_MUL   = 30'd991146300;
  localparam int unsigned DIV13_SHIFT = 36;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTS_PER_LINE  = 3'd0,
    CFG_SKIP_LINES       = 3'd1,
    CFG_PERIOD_TOLERANCE = 3'd2,
    CFG_LEFT_LIMIT       = 3'd3,
    CFG_RIGHT_LIMIT      = 3'd4,
    CFG_TRACK_WIDTH      = 3'd5
  } cfg_idx_e;

  localparam logic [POS_W-1:0] RST_POINTS_PER_LINE  = 8'd200;
  localparam logic [POS_W-1:0] RST_SKIP_LINES       = 8'd10;
  localparam logic [POS_W-1:0] RST_PERIOD_TOLERANCE = 8'd10;
  localparam logic [POS_W-1:0] RST_LEFT_LIMIT       = 8'd5;
  localparam logic [POS_W-1:0] RST_RIGHT_LIMIT      = 8'd195;
  localparam logic [POS_W-1:0] RST_TRACK_WIDTH      = 8'd100;

  typedef enum logic [1:0] {
    OP_FRAME_SYNC = 2'd0,
    OP_LINE_SYNC  = 2'd1,
    OP_EDGE       = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [TIMER_W-1:0] timer_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] line_index;
    logic [POS_W-1:0] left_edge;
    logic [POS_W-1:0] center;
    logic [POS_W-1:0] right_edge;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
  } line_edges_t;

endpackage

// ----- src/stc_ram.sv -----
// ----------------------------------------------------------------------------
// stc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/stc_div13.sv -----
// ----------------------------------------------------------------------------
// stc_div13
// Unsigned 32-bit divide by 13 through a reciprocal multiplication.
// ----------------------------------------------------------------------------
module stc_div13 (
  input  logic [stc_pkg::TIMER_W-1:0] dividend_i,
  output logic [stc_pkg::QUOT_W-1:0]  quotient_o
);
  import stc_pkg::*;

  logic [61:0] prod;
  logic [65:0] total;

  // The reciprocal is 2^32 + DIV13_MUL, so the upper part is a plain shift.
  assign prod  = 62'(dividend_i) * 62'(DIV13_MUL);
  assign total = {2'b00, dividend_i, 32'd0} + 66'(prod);

  assign quotient_o = total[DIV13_SHIFT +: QUOT_W];

endmodule

// ----- src/scanline_track_edge_center.sv -----
// ----------------------------------------------------------------------------
// scanline_track_edge_center
// Tracks the left and right edge of a track on each scan line and reports
// the repaired edges and the track center of every valid line.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in channel (valid/ready): frame sync, line sync or
// comparator edge, each with a down-counting timer reading. Each accepted
// line sync that closes a valid line produces one result on the out channel
// (valid/ready); all other requests produce nothing.
// One request is taken per cycle while in_ready_o is high. Each result is
// registered in the output register, or in the skid entry while the output
// is held. The datapath is a single registered stage: one divide-by-13
// reciprocal multiplier, the edge repair adders, and the line RAM read port,
// which fetches the next line's edges in the cycle the line counter moves.
// An output register plus one skid entry decouple the channels: while the
// receiver stalls, requests keep flowing until a second result is buffered,
// then in_ready_o drops until the output drains.
// Reset clears all counters, the valid bit of every line and loads the
// register defaults; the block is ready as soon as reset is released.
// Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
module scanline_track_edge_center (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  stc_pkg::in_item_t            in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output stc_pkg::out_item_t           out_o
);
  import stc_pkg::*;

  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINES - 1);

  // Configuration registers
  logic [POS_W-1:0] ppl_q, skip_lines_q, tol_q, left_lim_q, right_lim_q, track_w_q;

  // Tracking state
  logic [LINE_W-1:0]  lc_q, lc_d;
  logic [POS_W-1:0]   skip_q, skip_d;
  logic [TIMER_W-1:0] line_start_q, line_start_d;
  logic [TIMER_W-1:0] prev_sync_q, prev_sync_d;
  logic               samp_q, samp_d;
  logic [POS_W-1:0]   prev_center_q, prev_center_d;

  // Edges of the current line, either held here or just fetched from the RAM
  logic [POS_W-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic             sel_q;
  logic             rvld_q;
  logic [LINES-1:0] vld_q;

  // Output register and skid entry
  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;

  logic               in_fire, out_fire, produce, reload, ram_we;
  line_edges_t        ram_rdata, ram_wdata;
  logic [POS_W-1:0]   eff_l, eff_r;
  logic [TIMER_W-1:0] dividend;
  logic [QUOT_W-1:0]  quot;
  logic [POS_W-1:0]   pos;
  logic               period_ok, lmiss, rmiss;
  logic [POS_W-1:0]   rep_l, rep_r, rep_c;
  logic [POS_W:0]     l_plus_tw, rep_sum;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign eff_l = sel_q ? (rvld_q ? ram_rdata.left  : '0) : cur_l_q;
  assign eff_r = sel_q ? (rvld_q ? ram_rdata.right : '0) : cur_r_q;

  // One divider serves both the edge position and the line period.
  assign dividend = (in_i.operation == OP_EDGE) ? (line_start_q - in_i.timer_value)
                                                : (prev_sync_q - in_i.timer_value);

  stc_div13 u_div13 (
    .dividend_i (dividend),
    .quotient_o (quot)
  );

  assign pos = quot[POS_W-1:0];

  // |quot - ppl| < tol, evaluated without any wrap.
  assign period_ok = ((QUOT_W+1)'(quot) < (QUOT_W+1)'({1'b0, ppl_q} + {1'b0, tol_q}))
                  && ((QUOT_W+1)'(quot) + (QUOT_W+1)'(tol_q) > (QUOT_W+1)'(ppl_q));

  assign lmiss     = eff_l <= left_lim_q;
  assign rmiss     = eff_r >= right_lim_q;
  assign l_plus_tw = {1'b0, eff_l} + {1'b0, track_w_q};

  always_comb begin
    rep_l = eff_l;
    rep_r = eff_r;
    if (lmiss && !rmiss) begin
      rep_l = (eff_r > track_w_q) ? (eff_r - track_w_q) : '0;
    end else if (!lmiss && rmiss) begin
      rep_r = (l_plus_tw < {1'b0, ppl_q}) ? l_plus_tw[POS_W-1:0] : ppl_q;
    end
  end

  assign rep_sum = {1'b0, rep_l} + {1'b0, rep_r};
  assign rep_c   = (lmiss && rmiss) ? (ppl_q >> 1) : rep_sum[POS_W:1];

  always_comb begin
    lc_d          = lc_q;
    skip_d        = skip_q;
    line_start_d  = line_start_q;
    prev_sync_d   = prev_sync_q;
    samp_d        = samp_q;
    prev_center_d = prev_center_q;
    cur_l_d       = eff_l;
    cur_r_d       = eff_r;
    reload        = 1'b0;
    ram_we        = 1'b0;
    produce       = 1'b0;
    res           = '0;
    if (in_fire) begin
      case (in_i.operation)
        OP_FRAME_SYNC: begin
          lc_d   = '0;
          skip_d = '0;
          reload = 1'b1;
        end
        OP_LINE_SYNC: begin
          samp_d = 1'b1;
          if (skip_q < skip_lines_q) begin
            skip_d      = skip_q + 1'b1;
            prev_sync_d = in_i.timer_value;
          end else if (lc_q < LINE_LAST) begin
            line_start_d = in_i.timer_value;
            prev_sync_d  = in_i.timer_value;
            if (period_ok) begin
              cur_l_d            = rep_l;
              cur_r_d            = rep_r;
              ram_we             = 1'b1;
              prev_center_d      = rep_sum[POS_W:1];
              produce            = 1'b1;
              res.line_index     = IDX_W'(lc_q);
              res.left_edge      = rep_l;
              res.center         = rep_c;
              res.right_edge     = rep_r;
              lc_d               = lc_q + 1'b1;
              reload             = 1'b1;
            end
          end
        end
        OP_EDGE: begin
          if (samp_q) begin
            ram_we = 1'b1;
            if (pos < prev_center_q) begin
              cur_l_d = pos;
            end else begin
              cur_r_d = pos;
              samp_d  = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign ram_wdata.left  = cur_l_d;
  assign ram_wdata.right = cur_r_d;

  stc_ram #(
    .WIDTH ($bits(line_edges_t)),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lc_q),
    .wdata_i (ram_wdata),
    .re_i    (reload),
    .raddr_i (lc_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q        <= RST_POINTS_PER_LINE;
      skip_lines_q <= RST_SKIP_LINES;
      tol_q        <= RST_PERIOD_TOLERANCE;
      left_lim_q   <= RST_LEFT_LIMIT;
      right_lim_q  <= RST_RIGHT_LIMIT;
      track_w_q    <= RST_TRACK_WIDTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POINTS_PER_LINE:  ppl_q        <= cfg_wdata_i;
        CFG_SKIP_LINES:       skip_lines_q <= cfg_wdata_i;
        CFG_PERIOD_TOLERANCE: tol_q        <= cfg_wdata_i;
        CFG_LEFT_LIMIT:       left_lim_q   <= cfg_wdata_i;
        CFG_RIGHT_LIMIT:      right_lim_q  <= cfg_wdata_i;
        CFG_TRACK_WIDTH:      track_w_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q          <= '0;
      skip_q        <= '0;
      line_start_q  <= '0;
      prev_sync_q   <= '0;
      samp_q        <= 1'b0;
      prev_center_q <= RST_POINTS_PER_LINE >> 1;
      cur_l_q       <= '0;
      cur_r_q       <= '0;
      sel_q         <= 1'b0;
      rvld_q        <= 1'b0;
      vld_q         <= '0;
    end else begin
      lc_q          <= lc_d;
      skip_q        <= skip_d;
      line_start_q  <= line_start_d;
      prev_sync_q   <= prev_sync_d;
      samp_q        <= samp_d;
      prev_center_q <= prev_center_d;
      cur_l_q       <= cur_l_d;
      cur_r_q       <= cur_r_d;
      sel_q         <= reload;
      if (reload) begin
        rvld_q <= vld_q[lc_d];
      end
      if (ram_we) begin
        vld_q[lc_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= produce;
        end
      end else if (produce) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (produce) begin
        out_q <= res;
      end
    end else if (produce) begin
      skid_q <= res;
    end
  end

  // The skid entry only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register is empty");

  // A fetch of the next line never collides with a write of the current one.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && reload) |-> (lc_d != lc_q))
    else $error("line RAM read and write hit the same line");

  // Every emitted line advances the line counter by one.
  a_line_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> (lc_q == $past(lc_q) + 1'b1))
    else $error("line counter did not advance after a valid line");

  // A result is never dropped: it lands in the output or the skid entry.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("result lost while the receiver stalled");

endmodule
